// ===== hdl/sbin_pkg.sv =====
package sbin_pkg;

  // binarization kinds
  localparam logic [2:0] KIND_BI   = 3'd0;
  localparam logic [2:0] KIND_TU   = 3'd1;
  localparam logic [2:0] KIND_EG   = 3'd2;
  localparam logic [2:0] KIND_SEG  = 3'd3;
  localparam logic [2:0] KIND_TEG  = 3'd4;
  localparam logic [2:0] KIND_STEG = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_KIND  = 2'd0;
  localparam logic [1:0] CFG_MODE  = 2'd1;
  localparam logic [1:0] CFG_PARAM = 2'd2;

  localparam logic [5:0] MAX_PARAM = 6'd32;

  // context groups
  localparam logic [1:0] GRP_BI = 2'd0;
  localparam logic [1:0] GRP_TU = 2'd1;
  localparam logic [1:0] GRP_EG = 2'd2;

  // controller states; the segment states also select the bin in the datapath
  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [ST_W-1:0] ST_CHECK = 4'd1;
  localparam logic [ST_W-1:0] ST_LEN   = 4'd2;
  localparam logic [ST_W-1:0] ST_BI    = 4'd3;
  localparam logic [ST_W-1:0] ST_UN    = 4'd4;
  localparam logic [ST_W-1:0] ST_TERM  = 4'd5;
  localparam logic [ST_W-1:0] ST_EGPRE = 4'd6;
  localparam logic [ST_W-1:0] ST_EGONE = 4'd7;
  localparam logic [ST_W-1:0] ST_EGSUF = 4'd8;
  localparam logic [ST_W-1:0] ST_SIGN  = 4'd9;
  localparam logic [ST_W-1:0] ST_ERR   = 4'd10;

  typedef struct packed {
    logic [ST_W-1:0] state;
    logic            load;
    logic            emit;
    logic            last;
  } sbin_cmd_t;

  typedef struct packed {
    logic err;
    logic en_bi;
    logic en_un;
    logic en_term;
    logic en_egpre;
    logic en_egone;
    logic en_egsuf;
    logic en_sign;
    logic seg_last;
    logic out_free;
  } sbin_sts_t;

endpackage

// ===== hdl/sbin_ctrl.sv =====
module sbin_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  sbin_pkg::sbin_sts_t sts,
  output sbin_pkg::sbin_cmd_t cmd
);

  logic [sbin_pkg::ST_W-1:0] state_r;
  logic [sbin_pkg::ST_W-1:0] state_nxt;
  logic [sbin_pkg::ST_W-1:0] seg_nxt;
  logic [15:0]               en;

  // first enabled segment after cur, idle when none is left
  function automatic logic [sbin_pkg::ST_W-1:0] next_seg(
    input logic [sbin_pkg::ST_W-1:0] cur,
    input logic [15:0]               env
  );
    logic [sbin_pkg::ST_W-1:0] r;
    logic                      found;
    r     = sbin_pkg::ST_IDLE;
    found = 1'b0;
    for (int s = int'(sbin_pkg::ST_BI); s <= int'(sbin_pkg::ST_SIGN); s++) begin
      if (!found && s > int'(cur) && env[s]) begin
        r     = sbin_pkg::ST_W'(s);
        found = 1'b1;
      end
    end
    return r;
  endfunction

  always_comb begin
    en = '0;
    en[sbin_pkg::ST_BI]    = sts.en_bi;
    en[sbin_pkg::ST_UN]    = sts.en_un;
    en[sbin_pkg::ST_TERM]  = sts.en_term;
    en[sbin_pkg::ST_EGPRE] = sts.en_egpre;
    en[sbin_pkg::ST_EGONE] = sts.en_egone;
    en[sbin_pkg::ST_EGSUF] = sts.en_egsuf;
    en[sbin_pkg::ST_SIGN]  = sts.en_sign;
  end

  assign seg_nxt   = next_seg(state_r, en);
  assign in_tready = (state_r == sbin_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.state = state_r;
    cmd.load  = in_tvalid && in_tready;
    cmd.emit  = 1'b0;
    cmd.last  = 1'b0;
    case (state_r)
      sbin_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = sbin_pkg::ST_CHECK;
      end
      sbin_pkg::ST_CHECK: begin
        state_nxt = sbin_pkg::ST_LEN;
      end
      sbin_pkg::ST_LEN: begin
        if (sts.err) state_nxt = sbin_pkg::ST_ERR;
        else         state_nxt = seg_nxt;
      end
      sbin_pkg::ST_ERR: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = sbin_pkg::ST_IDLE;
        end
      end
      sbin_pkg::ST_BI, sbin_pkg::ST_UN, sbin_pkg::ST_TERM, sbin_pkg::ST_EGPRE,
      sbin_pkg::ST_EGONE, sbin_pkg::ST_EGSUF, sbin_pkg::ST_SIGN: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.seg_last) begin
            cmd.last  = (seg_nxt == sbin_pkg::ST_IDLE);
            state_nxt = seg_nxt;
          end
        end
      end
      default: state_nxt = sbin_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sbin_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== hdl/sbin_dp.sv =====
module sbin_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic signed [15:0]  in_tdata,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [5:0]          cfg_data,
  input  sbin_pkg::sbin_cmd_t cmd,
  output sbin_pkg::sbin_sts_t sts,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,
  output logic                out_tlast,
  output logic                out_tuser
);

  // configuration
  logic [2:0]  kind_r;
  logic        mode_r;
  logic [5:0]  param_r;

  // symbol
  logic        neg_r;
  logic [16:0] mag_r;
  logic [16:0] mag_in;

  // plan of the bin run
  logic        err_r,  err_c;
  logic [5:0]  u_r,    u_c;
  logic        term_r, term_c;
  logic        eg_r,   eg_c;
  logic        bi_r,   bi_c;
  logic        sign_r, sign_c;
  logic [16:0] x_r,    x_c;
  logic        teg_ge;
  logic [4:0]  len_r;
  logic [5:0]  cnt_r;

  // output beat
  logic        out_valid_r;
  logic        bin_r, byp_r, last_r, rerr_r;
  logic [1:0]  grp_r;
  logic [5:0]  slot_r;

  logic        bin_c, byp_c, rerr_c;
  logic [1:0]  grp_c;
  logic [5:0]  slot_c;
  logic [5:0]  bi_idx;
  logic [4:0]  suf_idx;
  logic [31:0] mag32, x32;

  function automatic logic [4:0] bit_len(input logic [16:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < 17; i++) begin
      if (v[i]) n = 5'(i + 1);
    end
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= sbin_pkg::KIND_BI;
      mode_r  <= 1'b0;
      param_r <= 6'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        sbin_pkg::CFG_KIND:  kind_r  <= cfg_data[2:0];
        sbin_pkg::CFG_MODE:  mode_r  <= cfg_data[0];
        sbin_pkg::CFG_PARAM: param_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // magnitude; the most negative symbol gives 0x8000
  assign mag_in = in_tdata[15] ? (17'h10000 - {1'b0, in_tdata}) : {1'b0, in_tdata};

  always_comb begin
    err_c = 1'b0;
    if (kind_r > sbin_pkg::KIND_STEG)
      err_c = 1'b1;
    else if ((kind_r inside {sbin_pkg::KIND_BI, sbin_pkg::KIND_TU,
                             sbin_pkg::KIND_EG, sbin_pkg::KIND_TEG}) && neg_r)
      err_c = 1'b1;
    else if (!(kind_r inside {sbin_pkg::KIND_EG, sbin_pkg::KIND_SEG}) &&
             param_r > sbin_pkg::MAX_PARAM)
      err_c = 1'b1;
    else if (kind_r == sbin_pkg::KIND_BI && param_r < 6'd32 &&
             (({15'b0, mag_r} >> param_r) != 32'd0))
      err_c = 1'b1;
    else if (kind_r == sbin_pkg::KIND_TU && mag_r > {11'b0, param_r})
      err_c = 1'b1;

    teg_ge = (mag_r >= {11'b0, param_r});
    case (kind_r)
      sbin_pkg::KIND_EG:  x_c = mag_r + 17'd1;
      // signed EG: 2*mag for negative or zero, 2*mag-1 otherwise, plus one
      sbin_pkg::KIND_SEG: x_c = {mag_r[15:0], 1'b0} + {16'b0, (neg_r || mag_r == 17'd0)};
      default:            x_c = mag_r - {11'b0, param_r} + 17'd1;
    endcase

    u_c    = 6'd0;
    term_c = 1'b0;
    eg_c   = 1'b0;
    bi_c   = 1'b0;
    sign_c = 1'b0;
    case (kind_r)
      sbin_pkg::KIND_BI: bi_c = (param_r != 6'd0);
      sbin_pkg::KIND_TU: begin
        u_c    = mag_r[5:0];
        term_c = (mag_r[5:0] != param_r);
      end
      sbin_pkg::KIND_EG, sbin_pkg::KIND_SEG: eg_c = 1'b1;
      sbin_pkg::KIND_TEG, sbin_pkg::KIND_STEG: begin
        u_c    = teg_ge ? param_r : mag_r[5:0];
        term_c = !teg_ge;
        eg_c   = teg_ge;
        sign_c = (kind_r == sbin_pkg::KIND_STEG) && (mag_r != 17'd0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= in_tdata[15];
      mag_r <= mag_in;
    end
    if (cmd.state == sbin_pkg::ST_CHECK) begin
      err_r  <= err_c;
      u_r    <= u_c;
      term_r <= term_c;
      eg_r   <= eg_c;
      bi_r   <= bi_c;
      sign_r <= sign_c;
      x_r    <= x_c;
    end
    if (cmd.state == sbin_pkg::ST_LEN) len_r <= bit_len(x_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n)        cnt_r <= 6'd0;
    else if (cmd.load) cnt_r <= 6'd0;
    else if (cmd.emit) cnt_r <= sts.seg_last ? 6'd0 : cnt_r + 6'd1;
  end

  always_comb begin
    sts.err      = err_r;
    sts.en_bi    = bi_r;
    sts.en_un    = (u_r != 6'd0);
    sts.en_term  = term_r;
    sts.en_egpre = eg_r && (x_r[16:1] != 16'd0);
    sts.en_egone = eg_r;
    sts.en_egsuf = eg_r && (x_r[16:1] != 16'd0);
    sts.en_sign  = sign_r;
    sts.out_free = !out_valid_r || out_tready;
    case (cmd.state)
      sbin_pkg::ST_BI:    sts.seg_last = ({1'b0, cnt_r} + 7'd1 == {1'b0, param_r});
      sbin_pkg::ST_UN:    sts.seg_last = ({1'b0, cnt_r} + 7'd1 == {1'b0, u_r});
      sbin_pkg::ST_EGPRE,
      sbin_pkg::ST_EGSUF: sts.seg_last = ({1'b0, cnt_r} + 7'd2 == {2'b0, len_r});
      default:            sts.seg_last = 1'b1;
    endcase
  end

  // bin of the current segment; fixed binary and suffix go MSB first
  assign mag32   = {15'b0, mag_r};
  assign x32     = {15'b0, x_r};
  assign bi_idx  = param_r - 6'd1 - cnt_r;
  assign suf_idx = len_r - 5'd2 - cnt_r[4:0];

  always_comb begin
    bin_c  = 1'b0;
    byp_c  = !mode_r;
    grp_c  = sbin_pkg::GRP_BI;
    slot_c = cnt_r;
    rerr_c = 1'b0;
    case (cmd.state)
      sbin_pkg::ST_BI: bin_c = mag32[bi_idx[4:0]];
      sbin_pkg::ST_UN: begin
        bin_c = 1'b1;
        grp_c = sbin_pkg::GRP_TU;
      end
      sbin_pkg::ST_TERM: begin
        grp_c  = sbin_pkg::GRP_TU;
        slot_c = u_r;
      end
      sbin_pkg::ST_EGPRE: grp_c = sbin_pkg::GRP_EG;
      sbin_pkg::ST_EGONE: begin
        bin_c  = 1'b1;
        grp_c  = sbin_pkg::GRP_EG;
        slot_c = {1'b0, len_r - 5'd1};
      end
      sbin_pkg::ST_EGSUF: begin
        bin_c = x32[suf_idx];
        byp_c = 1'b1;
      end
      sbin_pkg::ST_SIGN: begin
        bin_c  = neg_r;
        slot_c = 6'd0;
      end
      default: begin
        byp_c  = 1'b0;
        slot_c = 6'd0;
        rerr_c = 1'b1;
      end
    endcase
    if (byp_c) begin
      grp_c  = 2'd0;
      slot_c = 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)          out_valid_r <= 1'b0;
    else if (cmd.emit)   out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      bin_r  <= bin_c;
      byp_r  <= byp_c;
      grp_r  <= grp_c;
      slot_r <= slot_c;
      last_r <= cmd.last;
      rerr_r <= rerr_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, slot_r, grp_r, byp_r, bin_r};
  assign out_tlast  = last_r;
  assign out_tuser  = rerr_r;

endmodule

// ===== hdl/symbol_binarizer_tu_eg_teg_top.sv =====
// Sequence: a symbol is accepted in idle, then the check and length states register its plan
// and bit length before the segment states emit its bins, one bin per cycle while out_tready
// is high; a range error gives one beat. The input is not ready again until the last bin of
// the symbol is emitted, and the bins leave through the single output register.
// Reset: rst_n synchronous, active low; clears the controller and the output valid,
// loads kind 0, mode 0, param 1. No memory to clear.
module symbol_binarizer_tu_eg_teg_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic signed [15:0] in_tdata,   // [15:0] symbol_value
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [15:0]        out_tdata,  // [0] bin_bit, [1] is_bypass, [3:2] ctx_group,
                                         // [9:4] ctx_slot, [15:10] zero
  output logic               out_tlast,  // last_bin
  output logic               out_tuser,  // [0] range_error
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [5:0]         cfg_data
);

  sbin_pkg::sbin_cmd_t cmd;
  sbin_pkg::sbin_sts_t sts;

  assign cfg_ready = 1'b1;

  sbin_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sbin_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== hdl/sbin_chk.sv =====
module sbin_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [5:0]  cfg_data
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)
                                  && $stable(out_tuser))
    else $error("output beat changed under stall");

  // one symbol at a time: setup follows every accepted symbol
  a_one_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted back to back");

  // error beat closes the symbol and carries no bin
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == 16'd0)
    else $error("malformed error beat");

  // bypass bins carry no context
  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[9:2] == 8'd0)
    else $error("bypass bin with context");

  a_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:2] != 2'd3 && out_tdata[15:10] == 6'd0)
    else $error("bad context group or padding");

endmodule

bind symbol_binarizer_tu_eg_teg_top sbin_chk u_sbin_chk (.*);
